### rtl/translation_moving_average_core_assert.svh
// Assertion macros for the RTL of the translation smoother.
`ifndef TRANSLATION_MOVING_AVERAGE_CORE_ASSERT_SVH
`define TRANSLATION_MOVING_AVERAGE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define TMA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tma assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high
`define TMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tma assertion failed");

`endif

### rtl/tma_pkg.sv
`timescale 1ns / 1ps
package tma_pkg;

  // Payload widths
  localparam int DATA_W  = 20;
  localparam int LIMIT_W = 11;

  // Defaults for the top-level parameters
  localparam int WINDOW_DEF    = 24;
  localparam int FRAC_BITS_DEF = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = LIMIT_W;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_X = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_Y = 1'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_X_RST = 11'd5;
  localparam logic [LIMIT_W-1:0] LIMIT_Y_RST = 11'd20;

  // Status of the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### rtl/tma_if.sv
`timescale 1ns / 1ps
// Input beat: one measured translation pair
interface tma_in_if;
  import tma_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] shift_x;
  logic signed [DATA_W-1:0] shift_y;
  modport source (output valid, shift_x, shift_y, input ready);
  modport sink (input valid, shift_x, shift_y, output ready);
endinterface

// Output beat: one smoothed translation pair
interface tma_out_if;
  import tma_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] mean_x;
  logic signed [DATA_W-1:0] mean_y;
  logic                     replaced;
  modport source (output valid, mean_x, mean_y, replaced, input ready);
  modport sink (input valid, mean_x, mean_y, replaced, output ready);
endinterface

### rtl/tma_div.sv
`timescale 1ns / 1ps
// Signed-by-unsigned serial divider, two restoring steps per cycle,
// quotient rounded toward zero. The divisor must be nonzero.
module tma_div #(
  parameter int DIVIDEND_W = 25,
  parameter int DIVISOR_W  = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output logic signed [DIVIDEND_W-1:0] quotient,
  output tma_pkg::div_status_t         status
);
  import tma_pkg::*;

  localparam int STEPS = (DIVIDEND_W + 1) / 2;
  localparam int PAD_W = 2 * STEPS;
  localparam int REM_W = DIVISOR_W + 1;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [REM_W-1:0]      rem;
  logic [PAD_W-1:0]      quo;
  logic [DIVISOR_W-1:0]  dsr;
  logic                  neg;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;
  logic [REM_W-1:0]      rem_next;
  logic [PAD_W-1:0]      quo_next;
  logic [DIVIDEND_W-1:0] mag;
  logic [DIVIDEND_W-1:0] quo_mag;

  // Take the magnitude of the dividend
  assign mag = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);

  // Two restoring steps, each with its own subtractor
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < 2; i++) begin
      rem_next = {rem_next[REM_W-2:0], quo_next[PAD_W-1]};
      quo_next = {quo_next[PAD_W-2:0], 1'b0};
      if (rem_next >= {1'b0, dsr}) begin
        rem_next    = rem_next - {1'b0, dsr};
        quo_next[0] = 1'b1;
      end
    end
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= PAD_W'(mag);
      dsr <= divisor;
      neg <= dividend[DIVIDEND_W-1];
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  // Restore the sign
  assign quo_mag       = quo[DIVIDEND_W-1:0];
  assign quotient      = neg ? DIVIDEND_W'(-quo_mag) : DIVIDEND_W'(quo_mag);
  assign status.busy   = busy;
  assign status.done   = done;

endmodule

### rtl/translation_moving_average_core.sv
`timescale 1ns / 1ps
// Translation smoother: moving average over the last WINDOW translation pairs,
// with outlier pairs replaced by the previous smoothed output.
//
// Channels: in_ch carries shift_x/shift_y (signed Q12.8), out_ch returns
// mean_x/mean_y and the replaced flag, one output beat per input beat, in order.
// Both use valid/ready; a beat moves when both are high at a clock edge.
// limit_x (index 0) and limit_y (index 1) are written through cfg_wr_en,
// cfg_index and cfg_data, and should be written only while the block is idle.
//
// One shared divider, two quotient bits per cycle, divides the x sum and then
// the y sum; each division runs through start, 13 steps and done.
// in_ch.ready is high only while no pair is in work.
// The output register holds a finished result while the receiver stalls and
// the next pair may already be taken; that pair then waits for the register.
//
// Reset (rst, synchronous) empties the window, clears the previous output to
// zero, the output valid, and loads the limits with 5 and 20.
module translation_moving_average_core #(
  parameter int WINDOW    = tma_pkg::WINDOW_DEF,
  parameter int FRAC_BITS = tma_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [tma_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tma_pkg::CFG_DATA_W-1:0]   cfg_data,
  tma_in_if.sink                           in_ch,
  tma_out_if.source                        out_ch
);
  import tma_pkg::*;
  `include "translation_moving_average_core_assert.svh"

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = DATA_W + $clog2(WINDOW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_STX  = 3'd2;
  localparam logic [2:0] S_WX   = 3'd3;
  localparam logic [2:0] S_STY  = 3'd4;
  localparam logic [2:0] S_WY   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]               state;
  logic [LIMIT_W-1:0]       limit_x;
  logic [LIMIT_W-1:0]       limit_y;
  logic [SLOT_W-1:0]        write_slot;
  logic [CNT_W-1:0]         fill_count;
  logic signed [SUM_W-1:0]  sum_x;
  logic signed [SUM_W-1:0]  sum_y;
  logic signed [DATA_W-1:0] mean_x;
  logic signed [DATA_W-1:0] mean_y;
  logic signed [DATA_W-1:0] val_x;
  logic signed [DATA_W-1:0] val_y;
  logic                     rej;
  logic [2*DATA_W-1:0]      ring [WINDOW];
  logic [2*DATA_W-1:0]      rd_word;
  logic signed [DATA_W-1:0] old_x;
  logic signed [DATA_W-1:0] old_y;
  logic                     full;
  logic                     accept;
  logic                     rej_now;
  logic                     div_start;
  logic signed [SUM_W-1:0]  div_dividend;
  logic signed [SUM_W-1:0]  div_quotient;
  div_status_t              div_status;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_mean_x;
  logic signed [DATA_W-1:0] out_mean_y;
  logic                     out_replaced;

  // Integer part above the limit, magnitude truncated toward zero
  function automatic logic over_limit(input logic signed [DATA_W-1:0] v,
                                      input logic [LIMIT_W-1:0] lim);
    logic [DATA_W-1:0] mag;
    mag = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    return (mag >> FRAC_BITS) > DATA_W'(lim);
  endfunction

  assign accept  = in_ch.valid && in_ch.ready;
  assign rej_now = over_limit(in_ch.shift_x, limit_x) || over_limit(in_ch.shift_y, limit_y);
  assign full    = (fill_count == CNT_W'(WINDOW));
  assign old_x   = rd_word[2*DATA_W-1:DATA_W];
  assign old_y   = rd_word[DATA_W-1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_x <= LIMIT_X_RST;
      limit_y <= LIMIT_Y_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LIMIT_X: limit_x <= cfg_data;
        REG_LIMIT_Y: limit_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window memory: read the slot being replaced, write the new pair
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      rd_word <= ring[write_slot];
    end
    if (state == S_SUM) begin
      ring[write_slot] <= {val_x, val_y};
    end
  end

  // Latch the accepted pair, replaced by the previous mean on an outlier
  always_ff @(posedge clk) begin
    if (accept) begin
      rej   <= rej_now;
      val_x <= rej_now ? mean_x : in_ch.shift_x;
      val_y <= rej_now ? mean_y : in_ch.shift_y;
    end
  end

  // Sequencer, running sums and window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      write_slot <= '0;
      fill_count <= '0;
      sum_x      <= '0;
      sum_y      <= '0;
      mean_x     <= '0;
      mean_y     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) state <= S_SUM;
        end
        S_SUM: begin
          sum_x <= sum_x - (full ? SUM_W'(old_x) : '0) + SUM_W'(val_x);
          sum_y <= sum_y - (full ? SUM_W'(old_y) : '0) + SUM_W'(val_y);
          write_slot <= (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
          if (!full) fill_count <= fill_count + 1'b1;
          state <= S_STX;
        end
        S_STX: state <= S_WX;
        S_WX: begin
          if (div_status.done) begin
            mean_x <= div_quotient[DATA_W-1:0];
            state  <= S_STY;
          end
        end
        S_STY: state <= S_WY;
        S_WY: begin
          if (div_status.done) begin
            mean_y <= div_quotient[DATA_W-1:0];
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Shared divider: x sum first, then y sum
  assign div_start    = (state == S_STX) || (state == S_STY);
  assign div_dividend = (state == S_STX) ? sum_x : sum_y;

  tma_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (fill_count),
    .quotient (div_quotient),
    .status   (div_status)
  );

  // Output register: load when free or being drained, drop after the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || out_ch.ready)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ch.ready)) begin
      out_mean_x   <= mean_x;
      out_mean_y   <= mean_y;
      out_replaced <= rej;
    end
  end

  assign in_ch.ready     = (state == S_IDLE);
  assign out_ch.valid    = out_valid;
  assign out_ch.mean_x   = out_mean_x;
  assign out_ch.mean_y   = out_mean_y;
  assign out_ch.replaced = out_replaced;

  // Checks
  `TMA_ASSERT_NOW(a_ready_not_busy, in_ch.ready, !div_status.busy)
  `TMA_ASSERT_NOW(a_fill_bounded, 1'b1, fill_count <= CNT_W'(WINDOW))
  `TMA_ASSERT_NEXT(a_accept_to_sum, accept, state == S_SUM)
  `TMA_ASSERT_NOW(a_done_when_waiting, div_status.done, state == S_WX || state == S_WY)

endmodule
